/* sv/lfrs_pkg.sv */
package lfrs_pkg;

  // Room table size and derived widths
  localparam int MAX_ROOMS = 128;
  localparam int ROOM_W    = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam int NUM_W     = $clog2(MAX_ROOMS + 1);

  // Fixed field widths
  localparam int TIME_W  = 32;
  localparam int BUSY_W  = 48;
  localparam int COUNT_W = 24;
  localparam int CFG_W   = 8;
  localparam int OUT_W   = 7;

  // Room count after reset
  localparam int ROOMS_RST = 128;

  // One room entry: busy-until time and booking count
  typedef struct packed {
    logic [BUSY_W-1:0]  busy;
    logic [COUNT_W-1:0] cnt;
  } entry_t;

  // Flags and update values from the shared datapath unit
  typedef struct packed {
    logic               is_free;
    logic               earlier;
    logic               more_used;
    logic [BUSY_W-1:0]  new_busy;
    logic [COUNT_W-1:0] new_cnt;
  } alu_res_t;

endpackage

/* sv/lfrs_table.sv */
module lfrs_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [lfrs_pkg::ROOM_W-1:0]  rd_addr_i,
  output lfrs_pkg::entry_t             rd_data_o,
  input  logic                         wr_en_i,
  input  logic [lfrs_pkg::ROOM_W-1:0]  wr_addr_i,
  input  lfrs_pkg::entry_t             wr_data_i,
  input  logic                         clr_i
);
  import lfrs_pkg::*;

  entry_t               mem [MAX_ROOMS];
  logic [MAX_ROOMS-1:0] valid_q;
  entry_t               rd_q;
  logic                 rd_vld_q;

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  // Track written entries; drop them all on a batch clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= valid_q[rd_addr_i];
      if (clr_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  // Unwritten entries read as zero
  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

/* sv/lfrs_alu.sv */
module lfrs_alu (
  input  lfrs_pkg::entry_t                   rd_i,
  input  logic [lfrs_pkg::TIME_W-1:0]        start_i,
  input  logic [lfrs_pkg::TIME_W-1:0]        end_i,
  input  logic [lfrs_pkg::BUSY_W-1:0]        best_busy_i,
  input  logic [lfrs_pkg::COUNT_W-1:0]       best_cnt_i,
  input  logic [lfrs_pkg::COUNT_W-1:0]       top_cnt_i,
  input  logic                               found_i,
  output lfrs_pkg::alu_res_t                 res_o
);
  import lfrs_pkg::*;

  logic [TIME_W-1:0] dur;
  logic [BUSY_W:0]   sum;
  logic [BUSY_W-1:0] start_ext;

  // Duration, zero when end is not after start
  assign dur       = (end_i > start_i) ? (end_i - start_i) : '0;
  assign start_ext = BUSY_W'(start_i);
  assign sum       = {1'b0, best_busy_i} + (BUSY_W + 1)'(dur);

  // Compares used during the scans
  assign res_o.is_free   = (rd_i.busy <= start_ext);
  assign res_o.earlier   = (rd_i.busy < best_busy_i);
  assign res_o.more_used = (rd_i.cnt > top_cnt_i);

  // Entry update: free room ends at start+dur, busy room extends with saturation
  assign res_o.new_busy = found_i ? (start_ext + BUSY_W'(dur)) :
                          (sum[BUSY_W] ? {BUSY_W{1'b1}} : sum[BUSY_W-1:0]);
  assign res_o.new_cnt  = (&best_cnt_i) ? best_cnt_i : (best_cnt_i + COUNT_W'(1));

endmodule

/* sv/lowest_free_room_scheduler.sv */
// Meeting room scheduler.
// Requests enter on in_valid_i / in_stall_o with start_time_i, end_time_i and
// last_request_i; starts are expected in non-decreasing order. Each request
// yields one result beat on out_valid_o / out_stall_i: the room assigned, a
// batch_done flag and, on the last request, the most-booked room.
// rooms_in_use_i is to be written on cfg_valid_i / cfg_ready_o only while idle;
// the block itself does not enforce this. With n active rooms, a request scans
// the room table one entry per cycle through the table's registered read port
// and stops at the first free room. The last request of a batch adds a second
// scan of all n entries for the booking counts; the whole table is cleared when
// that scan reaches its last entry. A new request is accepted once the previous
// result sits in the output register; if that register is still stalled, the
// next result waits in the finish state and in_stall_o stays high.
// Reset clears the table, sets rooms_in_use to 128 and empties the output.
module lowest_free_room_scheduler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lfrs_pkg::CFG_W-1:0]      rooms_in_use_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [lfrs_pkg::TIME_W-1:0]     start_time_i,
  input  logic [lfrs_pkg::TIME_W-1:0]     end_time_i,
  input  logic                            last_request_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lfrs_pkg::OUT_W-1:0]      assigned_room_o,
  output logic                            batch_done_o,
  output logic [lfrs_pkg::OUT_W-1:0]      most_booked_room_o
);
  import lfrs_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_CNT  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [CFG_W-1:0]   rooms_q;
  logic [NUM_W-1:0]   num_rooms;
  logic [NUM_W-1:0]   last_idx;
  logic [NUM_W-1:0]   ra_q, ra_d;
  logic               dv_q, dv_d;
  logic [ROOM_W-1:0]  didx_q;
  logic               at_end;
  logic               found_q, found_d;
  logic [ROOM_W-1:0]  best_idx_q, best_idx_d;
  logic [BUSY_W-1:0]  best_busy_q, best_busy_d;
  logic [COUNT_W-1:0] best_cnt_q, best_cnt_d;
  logic [ROOM_W-1:0]  top_idx_q, top_idx_d;
  logic [COUNT_W-1:0] top_cnt_q, top_cnt_d;
  logic [TIME_W-1:0]  start_q, end_q;
  logic               last_q;
  logic               out_valid_q, out_valid_d;
  logic [OUT_W-1:0]   room_out_q, most_out_q;
  logic               done_out_q;
  logic               out_load;
  logic               wr_en;
  logic               clr;
  entry_t             rd_data;
  entry_t             wr_data;
  alu_res_t           alu;

  // Effective room count: zero acts as one, clamp at table size
  always_comb begin
    if (rooms_q == '0) begin
      num_rooms = NUM_W'(1);
    end else if (32'(rooms_q) > 32'(MAX_ROOMS)) begin
      num_rooms = NUM_W'(MAX_ROOMS);
    end else begin
      num_rooms = NUM_W'(rooms_q);
    end
  end
  assign last_idx = num_rooms - NUM_W'(1);
  assign at_end   = (NUM_W'(didx_q) == last_idx);

  lfrs_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (ra_q[ROOM_W-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (best_idx_q),
    .wr_data_i (wr_data),
    .clr_i     (clr)
  );

  lfrs_alu u_alu (
    .rd_i        (rd_data),
    .start_i     (start_q),
    .end_i       (end_q),
    .best_busy_i (best_busy_q),
    .best_cnt_i  (best_cnt_q),
    .top_cnt_i   (top_cnt_q),
    .found_i     (found_q),
    .res_o       (alu)
  );

  assign wr_data.busy = alu.new_busy;
  assign wr_data.cnt  = alu.new_cnt;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    ra_d        = ra_q;
    dv_d        = 1'b0;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_busy_d = best_busy_q;
    best_cnt_d  = best_cnt_q;
    top_idx_d   = top_idx_q;
    top_cnt_d   = top_cnt_q;
    wr_en       = 1'b0;
    clr         = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
          ra_d    = '0;
          found_d = 1'b0;
        end
      end
      ST_SCAN: begin
        // issue the next read
        if (ra_q < num_rooms) begin
          dv_d = 1'b1;
          ra_d = ra_q + NUM_W'(1);
        end
        // take the first free room, else track the earliest-ending one
        if (dv_q) begin
          if (alu.is_free) begin
            found_d    = 1'b1;
            best_idx_d = didx_q;
            best_cnt_d = rd_data.cnt;
            state_d    = ST_UPD;
          end else begin
            if ((didx_q == '0) || alu.earlier) begin
              best_idx_d  = didx_q;
              best_busy_d = rd_data.busy;
              best_cnt_d  = rd_data.cnt;
            end
            if (at_end) begin
              state_d = ST_UPD;
            end
          end
        end
      end
      ST_UPD: begin
        wr_en   = 1'b1;
        ra_d    = '0;
        state_d = last_q ? ST_CNT : ST_FIN;
      end
      ST_CNT: begin
        if (ra_q < num_rooms) begin
          dv_d = 1'b1;
          ra_d = ra_q + NUM_W'(1);
        end
        // strict compare keeps the lowest index on ties
        if (dv_q) begin
          if ((didx_q == '0) || alu.more_used) begin
            top_idx_d = didx_q;
            top_cnt_d = rd_data.cnt;
          end
          if (at_end) begin
            clr     = 1'b1;
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rooms_q     <= CFG_W'(ROOMS_RST);
      ra_q        <= '0;
      dv_q        <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ra_q        <= ra_d;
      dv_q        <= dv_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        rooms_q <= rooms_in_use_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    didx_q      <= ra_q[ROOM_W-1:0];
    best_idx_q  <= best_idx_d;
    best_busy_q <= best_busy_d;
    best_cnt_q  <= best_cnt_d;
    top_idx_q   <= top_idx_d;
    top_cnt_q   <= top_cnt_d;
    if (state_q == ST_IDLE && in_valid_i) begin
      start_q <= start_time_i;
      end_q   <= end_time_i;
      last_q  <= last_request_i;
    end
    if (out_load) begin
      room_out_q <= OUT_W'(best_idx_q);
      done_out_q <= last_q;
      most_out_q <= last_q ? OUT_W'(top_idx_q) : '0;
    end
  end

  assign cfg_ready_o        = 1'b1;
  assign in_stall_o         = (state_q != ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign assigned_room_o    = room_out_q;
  assign batch_done_o       = done_out_q;
  assign most_booked_room_o = most_out_q;

`ifndef SYNTH
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_SCAN))
    else $error("accepted request did not start a scan");

  a_update_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> (NUM_W'(best_idx_q) < num_rooms))
    else $error("chosen room outside active range");

  a_scan_data_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_q && (state_q == ST_SCAN || state_q == ST_CNT)) |->
      (NUM_W'(didx_q) < num_rooms))
    else $error("scan read beyond active rooms");

  a_finish_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_o && (state_q == ST_IDLE)))
    else $error("finished result not presented");
`endif

endmodule

/* tb/lowest_free_room_scheduler_checker.sv */
`timescale 1ns / 100ps

module lowest_free_room_scheduler_checker
  import lfrs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_W-1:0]     rooms_in_use_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [TIME_W-1:0]    start_time_i,
  input  logic [TIME_W-1:0]    end_time_i,
  input  logic                 last_request_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [OUT_W-1:0]     assigned_room_i,
  input  logic                 batch_done_i,
  input  logic [OUT_W-1:0]     most_booked_room_i,
  output int unsigned          fail_count_o,
  output int unsigned          open_count_o
);

  localparam logic [BUSY_W-1:0]  BUSY_TOP  = '1;
  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

  typedef struct packed {
    logic [OUT_W-1:0] room;
    logic             done;
    logic [OUT_W-1:0] top_room;
  } booking_t;

  // Shadow room table and room count register
  logic [BUSY_W-1:0]  busy_tbl [MAX_ROOMS];
  logic [COUNT_W-1:0] uses_tbl [MAX_ROOMS];
  logic [CFG_W-1:0]   room_setting;
  booking_t           pending_bookings [$];
  int unsigned        mismatches;

  initial begin
    fail_count_o = 0;
    open_count_o = 0;
  end

  task automatic clear_rooms();
    for (int i = 0; i < MAX_ROOMS; i++) begin
      busy_tbl[i] = '0;
      uses_tbl[i] = '0;
    end
  endtask

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%t: %s", $realtime, msg);
  endtask

  // Assign one meeting to a room and queue the expected result beat
  task automatic book_meeting(input logic [TIME_W-1:0] start_t, input logic [TIME_W-1:0] end_t,
                              input logic last_req);
    logic [BUSY_W-1:0] dur;
    logic [BUSY_W-1:0] start_w;
    int                n;
    int                room;
    int                top_idx;
    bit                found;
    booking_t          b;
    start_w = BUSY_W'(start_t);
    dur     = (end_t > start_t) ? BUSY_W'(end_t - start_t) : '0;
    // out-of-range counts clamp to 1 .. MAX_ROOMS
    n = (room_setting == '0) ? 1 :
        ((int'(room_setting) > MAX_ROOMS) ? MAX_ROOMS : int'(room_setting));
    found = 1'b0;
    room  = 0;
    for (int i = 0; i < n; i++) begin
      if (!found && busy_tbl[i] <= start_w) begin
        room  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      busy_tbl[room] = start_w + dur;
    end else begin
      // no free room: earliest to free, lowest index on ties, extend saturating
      for (int i = 1; i < n; i++) begin
        if (busy_tbl[i] < busy_tbl[room]) room = i;
      end
      if (busy_tbl[room] > BUSY_TOP - dur) busy_tbl[room] = BUSY_TOP;
      else busy_tbl[room] = busy_tbl[room] + dur;
    end
    if (uses_tbl[room] != COUNT_TOP) uses_tbl[room] = uses_tbl[room] + 1'b1;
    b.room     = OUT_W'(room);
    b.done     = last_req;
    b.top_room = '0;
    if (last_req) begin
      top_idx = 0;
      for (int i = 1; i < n; i++) begin
        if (uses_tbl[i] > uses_tbl[top_idx]) top_idx = i;
      end
      b.top_room = OUT_W'(top_idx);
      clear_rooms();
    end
    pending_bookings.push_back(b);
  endtask

  // Watch all three channels, compare results against the oldest booking
  always @(posedge clk_i or negedge rst_ni) begin
    booking_t want;
    if (!rst_ni) begin
      clear_rooms();
      room_setting = 8'd128;
      pending_bookings.delete();
      mismatches = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_bookings.size() == 0) begin
          note_failure($sformatf("result beat with nothing expected: room %0d done %0b",
                                 assigned_room_i, batch_done_i));
        end else begin
          want = pending_bookings.pop_front();
          if (assigned_room_i !== want.room)
            note_failure($sformatf("assigned_room: expected %0d, got %0d",
                                   want.room, assigned_room_i));
          if (batch_done_i !== want.done)
            note_failure($sformatf("batch_done: expected %0b, got %0b",
                                   want.done, batch_done_i));
          if (most_booked_room_i !== want.top_room)
            note_failure($sformatf("most_booked_room: expected %0d, got %0d",
                                   want.top_room, most_booked_room_i));
        end
      end
      if (in_valid_i && !in_stall_i) book_meeting(start_time_i, end_time_i, last_request_i);
      if (cfg_valid_i && cfg_ready_i) room_setting = rooms_in_use_i;
    end
    fail_count_o <= mismatches;
    open_count_o <= pending_bookings.size();
  end

endmodule

/* tb/lowest_free_room_scheduler_tb.sv */
`timescale 1ns / 100ps

module lowest_free_room_scheduler_tb;
  import lfrs_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1330;
  localparam int unsigned QUIET_LIMIT  = 3000;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               cfg_valid    = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   rooms_in_use = '0;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [TIME_W-1:0]  start_time   = '0;
  logic [TIME_W-1:0]  end_time     = '0;
  logic               last_request = 1'b0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic [OUT_W-1:0]   assigned_room;
  logic               batch_done;
  logic [OUT_W-1:0]   most_booked_room;
  logic               calm         = 1'b0;
  int unsigned        fail_count;
  int unsigned        open_count;
  int unsigned        quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lowest_free_room_scheduler i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .rooms_in_use_i     (rooms_in_use),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .start_time_i       (start_time),
    .end_time_i         (end_time),
    .last_request_i     (last_request),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .assigned_room_o    (assigned_room),
    .batch_done_o       (batch_done),
    .most_booked_room_o (most_booked_room)
  );

  lowest_free_room_scheduler_checker i_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .rooms_in_use_i     (rooms_in_use),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .start_time_i       (start_time),
    .end_time_i         (end_time),
    .last_request_i     (last_request),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .assigned_room_i    (assigned_room),
    .batch_done_i       (batch_done),
    .most_booked_room_i (most_booked_room),
    .fail_count_o       (fail_count),
    .open_count_o       (open_count)
  );

  // Stall the result channel at random, never during the calm stretch
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 11);
  end

  // End the run when no beat moves on any channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Offer one request beat after an optional random gap, hold until taken
  task automatic send_request(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] e,
                              input logic l);
    while (!calm && ($urandom_range(0, 99) < 11)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    start_time   <= s;
    end_time     <= e;
    last_request <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold off new requests until every booked result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
  endtask

  task automatic set_rooms(input logic [CFG_W-1:0] v);
    drain();
    cfg_valid    <= 1'b1;
    rooms_in_use <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned        sent;
    int unsigned        phase_len;
    int unsigned        batch_left;
    int unsigned        step_max;
    int unsigned        dur_max;
    int                 r;
    logic [63:0]        now_t;
    logic [63:0]        stop_t;
    logic [TIME_W-1:0]  s;
    logic [TIME_W-1:0]  e;
    logic               l;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty and full-range meetings, end at or before start
    send_request(32'd0, 32'd0, 1'b0);
    send_request(32'd0, 32'hFFFF_FFFF, 1'b0);
    send_request(32'd0, 32'd1, 1'b0);
    send_request(32'd5, 32'd3, 1'b0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    // single room: extend a busy room, zero-length extension
    set_rooms(8'd1);
    send_request(32'd10, 32'd20, 1'b0);
    send_request(32'd12, 32'd30, 1'b0);
    send_request(32'd12, 32'd12, 1'b0);
    send_request(32'd40, 32'd50, 1'b1);
    // zero room count acts as one; busy time grows past 32 bits
    set_rooms(8'd0);
    send_request(32'd100, 32'hFFFF_FFFF, 1'b0);
    send_request(32'd200, 32'hFFFF_FFFF, 1'b0);
    send_request(32'd300, 32'd400, 1'b1);
    // count above the table size clamps; starts out of order
    set_rooms(8'd255);
    send_request(32'd0, 32'd1000, 1'b0);
    send_request(32'd0, 32'd1000, 1'b0);
    send_request(32'd900, 32'd2000, 1'b0);
    send_request(32'd3, 32'd4, 1'b0);
    send_request(32'd2, 32'd3, 1'b1);
    // shrink the room count with a batch still open
    set_rooms(8'd3);
    send_request(32'd5, 32'd6, 1'b0);
    send_request(32'd5, 32'd9, 1'b0);
    set_rooms(8'd2);
    send_request(32'd6, 32'd7, 1'b0);
    send_request(32'd8, 32'd9, 1'b1);

    // Random phases: new room count, then batches of ordered requests plus noise
    sent       = 0;
    batch_left = 0;
    step_max   = 1;
    dur_max    = 1;
    now_t      = '0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 55)      set_rooms(CFG_W'($urandom_range(1, 8)));
      else if (r < 70) set_rooms(CFG_W'($urandom_range(9, 40)));
      else if (r < 78) set_rooms(8'd128);
      else if (r < 84) set_rooms(8'd0);
      else             set_rooms(CFG_W'($urandom_range(0, 255)));
      calm      <= (sent >= 500) && (sent < 800);
      phase_len = $urandom_range(20, 150);
      repeat (phase_len) begin
        if (batch_left == 0) begin
          batch_left = $urandom_range(1, 40);
          r = $urandom_range(0, 99);
          if (r < 50) begin
            step_max = $urandom_range(0, 8);
            dur_max  = $urandom_range(1, 60);
          end else if (r < 80) begin
            step_max = $urandom_range(0, 100);
            dur_max  = $urandom_range(1, 5000);
          end else begin
            step_max = $urandom_range(0, 32'h1000_0000);
            dur_max  = $urandom_range(1, 32'hFFFF_FFFF);
          end
          now_t = ($urandom_range(0, 99) < 60) ? 64'($urandom_range(0, 1000))
                                               : 64'($urandom());
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
          s = $urandom();
          e = $urandom();
        end else begin
          now_t = now_t + $urandom_range(0, step_max);
          if (now_t > 64'hFFFF_FFFF) now_t = 64'hFFFF_FFFF;
          s = now_t[31:0];
          r = $urandom_range(0, 99);
          if (r < 5) begin
            e = s;
          end else if (r < 8) begin
            e = s - $urandom_range(1, 50);
          end else begin
            stop_t = now_t + $urandom_range(1, dur_max);
            if (stop_t > 64'hFFFF_FFFF) stop_t = 64'hFFFF_FFFF;
            e = stop_t[31:0];
          end
        end
        batch_left = batch_left - 1;
        l = (batch_left == 0);
        send_request(s, e, l);
        sent++;
      end
    end

    // Wait for the last results, let the block settle, then give the verdict
    calm <= 1'b0;
    drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
